### design/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CHK_IMPLY(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Implication checked on every clock edge, reset included.
`define CHK_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

### design/bfpa_pkg.sv
// ----------------------------------------------------------------------------
// bfpa_pkg
// Types and constants of the best-fit page allocator.
// ----------------------------------------------------------------------------
package bfpa_pkg;
   localparam int MaxChunksDefault   = 64;
   localparam int PageBytesDefault   = 4096;
   localparam int HeaderBytesDefault = 32;
   localparam int HeapPagesDefault   = 4096;

   localparam logic       FUNC_ALLOC = 1'b0;
   localparam logic       FUNC_FREE  = 1'b1;
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_OOM     = 2'd1;
   localparam logic [1:0] ST_BADFREE = 2'd2;

   typedef struct packed {
      logic        func;
      logic [23:0] payload_bytes;
      logic [11:0] chunk_page;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [11:0] granted_page;
      logic [12:0] granted_pages;
      logic [12:0] heap_end_page;
   } rsp_type;
endpackage

### design/best_fit_page_allocator_top.sv
// ----------------------------------------------------------------------------
// best_fit_page_allocator_top
// Page-granular best-fit heap allocator with coalescing over a chunk table.
// ----------------------------------------------------------------------------
// One request is taken at a clock edge with start high and busy low; its single
// result appears for one cycle on rsp_valid and cannot be stalled, and busy
// stays high through that result cycle. A demand larger than the heap holds
// busy for the shortest time, and a split of the first chunk for the longest.
// The single-port chunk memory is scanned one entry at a time (read, then
// compare), and every entry moved for an insert or a remove is read, then
// written.
module best_fit_page_allocator_top
   import bfpa_pkg::*;
#(
   parameter int MAX_CHUNKS   = MaxChunksDefault,
   parameter int PAGE_BYTES   = PageBytesDefault,
   parameter int HEADER_BYTES = HeaderBytesDefault,
   parameter int HEAP_PAGES   = HeapPagesDefault
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);
   localparam int IW = $clog2(MAX_CHUNKS);
   localparam int CW = $clog2(MAX_CHUNKS + 1);
   localparam int PW = 17;
   localparam int PSH = $clog2(PAGE_BYTES);

   typedef struct packed {
      logic [PW-1:0] start;
      logic [PW-1:0] size;
      logic          used;
   } entry_type;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_SCAN   = 4'd1;
   localparam logic [3:0] S_SCANW  = 4'd2;
   localparam logic [3:0] S_DECIDE = 4'd3;
   localparam logic [3:0] S_SHR    = 4'd4;
   localparam logic [3:0] S_SHRW   = 4'd5;
   localparam logic [3:0] S_SHL    = 4'd6;
   localparam logic [3:0] S_SHLW   = 4'd7;
   localparam logic [3:0] S_RDA    = 4'd8;
   localparam logic [3:0] S_RDAW   = 4'd9;
   localparam logic [3:0] S_FREE1  = 4'd10;
   localparam logic [3:0] S_FREE2  = 4'd11;
   localparam logic [3:0] S_TAIL   = 4'd12;
   localparam logic [3:0] S_DONE   = 4'd13;

   // Chunk memory, one port, registered read.
   entry_type mem [MAX_CHUNKS];
   entry_type rd_ff;
   logic          we;
   logic [IW-1:0] addr;
   entry_type     wdata;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rd_ff <= mem[addr];
   end

   logic [3:0]    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [PW-1:0] heap_ff, heap_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] best_ff, best_in;
   logic [PW-1:0] bestsz_ff, bestsz_in;
   logic          found_ff, found_in, exact_ff, exact_in;
   logic          isfree_ff, isfree_in;
   logic [PW-1:0] need_ff, need_in;
   logic [11:0]   page_ff, page_in;
   logic [1:0]    status_ff, status_in;
   logic [11:0]   gpage_ff, gpage_in;
   logic [PW-1:0] gsize_ff, gsize_in;
   // Entry held for the pending write after a shift, and the chunks seen in a free.
   entry_type     hold_ff, hold_in;
   entry_type     cur_ff, cur_in;
   entry_type     prv_ff, prv_in;
   logic [CW-1:0] stop_ff, stop_in;
   logic [1:0]    phase_ff, phase_in;
   logic          rspv_ff, rspv_in;

   logic [24:0] sum;
   logic [PW-1:0] need_calc;
   assign sum = {1'b0, req_data.payload_bytes} + 25'(HEADER_BYTES);
   assign need_calc = PW'(sum >> PSH) + PW'(1);

   always_comb begin
      state_in = state_ff; count_in = count_ff; heap_in = heap_ff;
      idx_in = idx_ff; best_in = best_ff; bestsz_in = bestsz_ff;
      found_in = found_ff; exact_in = exact_ff; isfree_in = isfree_ff;
      need_in = need_ff; page_in = page_ff; status_in = status_ff;
      gpage_in = gpage_ff; gsize_in = gsize_ff; hold_in = hold_ff;
      cur_in = cur_ff; prv_in = prv_ff; stop_in = stop_ff; phase_in = phase_ff;
      rspv_in = 1'b0;
      we = 1'b0; addr = idx_ff[IW-1:0]; wdata = hold_ff;
      case (state_ff)
         S_IDLE: begin
            // The result cycle still counts as busy, so no transfer is taken then.
            if (start && !rspv_ff) begin
               isfree_in = (req_data.func == FUNC_FREE);
               need_in = need_calc;
               page_in = req_data.chunk_page;
               found_in = 1'b0; exact_in = 1'b0;
               idx_in = '0; status_in = ST_OK;
               gpage_in = '0; gsize_in = '0;
               if (req_data.func == FUNC_ALLOC && need_calc > PW'(HEAP_PAGES)) begin
                  status_in = ST_OOM; state_in = S_DONE;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         // Read entries one at a time.
         S_SCAN: begin
            if (idx_ff >= count_ff) begin
               state_in = S_DECIDE;
            end else begin
               addr = idx_ff[IW-1:0];
               state_in = S_SCANW;
            end
         end
         S_SCANW: begin
            state_in = S_SCAN;
            idx_in = idx_ff + CW'(1);
            if (isfree_ff) begin
               if (rd_ff.start == PW'(page_ff)) begin
                  found_in = 1'b1; best_in = idx_ff; cur_in = rd_ff;
                  state_in = S_DECIDE;
               end else begin
                  prv_in = rd_ff;
               end
            end else if (!rd_ff.used) begin
               if (rd_ff.size == need_ff) begin
                  found_in = 1'b1; exact_in = 1'b1; best_in = idx_ff;
                  cur_in = rd_ff; state_in = S_DECIDE;
               end else if (rd_ff.size > need_ff &&
                            (!found_ff || rd_ff.size < bestsz_ff)) begin
                  found_in = 1'b1; best_in = idx_ff; bestsz_in = rd_ff.size;
                  cur_in = rd_ff;
               end
            end
         end
         S_DECIDE: begin
            if (isfree_ff) begin
               if (!found_ff || !cur_ff.used) begin
                  status_in = ST_BADFREE; state_in = S_DONE;
               end else begin
                  cur_in.used = 1'b0; phase_in = 2'd0;
                  state_in = S_FREE1;
               end
            end else if (found_ff && exact_ff) begin
               we = 1'b1; addr = best_ff[IW-1:0];
               wdata = '{start: cur_ff.start, size: cur_ff.size, used: 1'b1};
               gpage_in = cur_ff.start[11:0]; gsize_in = need_ff;
               state_in = S_DONE;
            end else if (found_ff) begin
               if (count_ff >= CW'(MAX_CHUNKS)) begin
                  status_in = ST_OOM; state_in = S_DONE;
               end else begin
                  // Write the used head, then open a slot for the free tail.
                  we = 1'b1; addr = best_ff[IW-1:0];
                  wdata = '{start: cur_ff.start, size: need_ff, used: 1'b1};
                  gpage_in = cur_ff.start[11:0]; gsize_in = need_ff;
                  hold_in = '{start: cur_ff.start + need_ff,
                              size: cur_ff.size - need_ff, used: 1'b0};
                  stop_in = best_ff + CW'(1);
                  idx_in = count_ff;
                  count_in = count_ff + CW'(1);
                  state_in = S_SHR;
               end
            end else begin
               if (count_ff >= CW'(MAX_CHUNKS) ||
                   need_ff > PW'(HEAP_PAGES) - heap_ff) begin
                  status_in = ST_OOM; state_in = S_DONE;
               end else begin
                  we = 1'b1; addr = count_ff[IW-1:0];
                  wdata = '{start: heap_ff, size: need_ff, used: 1'b1};
                  gpage_in = heap_ff[11:0]; gsize_in = need_ff;
                  heap_in = heap_ff + need_ff;
                  count_in = count_ff + CW'(1);
                  state_in = S_DONE;
               end
            end
         end
         // Shift right: entry idx-1 moves to idx until idx reaches stop.
         S_SHR: begin
            if (idx_ff == stop_ff) begin
               we = 1'b1; addr = idx_ff[IW-1:0]; wdata = hold_ff;
               state_in = S_DONE;
            end else begin
               addr = IW'(idx_ff - CW'(1));
               state_in = S_SHRW;
            end
         end
         S_SHRW: begin
            we = 1'b1; addr = idx_ff[IW-1:0]; wdata = rd_ff;
            idx_in = idx_ff - CW'(1);
            state_in = S_SHR;
         end
         // Free: merge with the next chunk, then with the previous one.
         S_FREE1: begin
            case (phase_ff)
               2'd0: begin
                  if (best_ff + CW'(1) < count_ff) begin
                     addr = IW'(best_ff + CW'(1)); state_in = S_RDA;
                  end else begin
                     phase_in = 2'd1;
                  end
               end
               2'd1: begin
                  if (best_ff != '0 && !prv_ff.used) begin
                     // Previous absorbs current; remove current.
                     prv_in.size = prv_ff.size + cur_ff.size;
                     we = 1'b1; addr = IW'(best_ff - CW'(1));
                     wdata = '{start: prv_ff.start, size: prv_ff.size + cur_ff.size,
                               used: 1'b0};
                     idx_in = best_ff; phase_in = 2'd2;
                     state_in = S_SHL;
                  end else begin
                     we = 1'b1; addr = best_ff[IW-1:0]; wdata = cur_ff;
                     state_in = S_TAIL;
                  end
               end
               default: state_in = S_TAIL;
            endcase
         end
         S_RDA: state_in = S_RDAW;
         S_RDAW: begin
            if (!rd_ff.used) begin
               cur_in.size = cur_ff.size + rd_ff.size;
               idx_in = best_ff + CW'(1);
               phase_in = 2'd1;
               state_in = S_SHL;
            end else begin
               phase_in = 2'd1; state_in = S_FREE1;
            end
         end
         // Shift left: entry idx+1 moves to idx, then the count drops.
         S_SHL: begin
            if (idx_ff + CW'(1) >= count_ff) begin
               count_in = count_ff - CW'(1);
               if (phase_ff == 2'd2) begin
                  best_in = best_ff - CW'(1);
                  state_in = S_TAIL;
               end else begin
                  state_in = S_FREE1;
               end
            end else begin
               addr = IW'(idx_ff + CW'(1));
               state_in = S_SHLW;
            end
         end
         S_SHLW: begin
            we = 1'b1; addr = idx_ff[IW-1:0]; wdata = rd_ff;
            idx_in = idx_ff + CW'(1);
            state_in = S_SHL;
         end
         // Release a free chunk left at the heap end.
         S_TAIL: begin
            if (best_ff + CW'(1) == count_ff) begin
               heap_in = (phase_ff == 2'd2) ? prv_ff.start : cur_ff.start;
               count_in = count_ff - CW'(1);
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            rspv_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         heap_ff <= '0;
         rspv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         heap_ff <= heap_in;
         rspv_ff <= rspv_in;
      end
      idx_ff <= idx_in; best_ff <= best_in; bestsz_ff <= bestsz_in;
      found_ff <= found_in; exact_ff <= exact_in; isfree_ff <= isfree_in;
      need_ff <= need_in; page_ff <= page_in; status_ff <= status_in;
      gpage_ff <= gpage_in; gsize_ff <= gsize_in; hold_ff <= hold_in;
      cur_ff <= cur_in; prv_ff <= prv_in; stop_ff <= stop_in;
      phase_ff <= phase_in;
   end

   // Result register, loaded in the done state; rsp_valid marks it for one cycle.
   rsp_type out_ff;
   always_ff @(posedge clock) begin
      if (state_ff == S_DONE) begin
         out_ff.status <= status_ff;
         out_ff.granted_page <= (status_ff == ST_OK) ? gpage_ff : 12'd0;
         out_ff.granted_pages <= (status_ff == ST_OK) ? gsize_ff[12:0] : 13'd0;
         out_ff.heap_end_page <= heap_ff[12:0];
      end
   end

   assign busy = (state_ff != S_IDLE) || rspv_ff;
   assign rsp_valid = rspv_ff;
   assign rsp_data = out_ff;
endmodule

### design/bfpa_checker.sv
// ----------------------------------------------------------------------------
// bfpa_checker
// Port-level checks of the allocator's command and result timing.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module bfpa_checker
   import bfpa_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_valid,
   input rsp_type rsp_data
);
   // A transfer in makes the block busy in the next cycle.
   `CHK_IMPLY(a_busy_after, clock, reset, (start && !busy) |=> busy, "not busy after transfer")
   // Results never come back to back.
   `CHK_IMPLY(a_single, clock, reset, rsp_valid |=> !rsp_valid, "result held two cycles")
   // Status code is in range.
   `CHK_IMPLY(a_status, clock, reset, rsp_valid |-> (rsp_data.status <= ST_BADFREE), "bad status")
   // Failed requests grant nothing.
   `CHK_IMPLY(a_zero, clock, reset,
      (rsp_valid && rsp_data.status != ST_OK) |-> (rsp_data.granted_pages == 13'd0),
      "grant on failure")
   // Reset leaves no result pending.
   `CHK_ALWAYS(a_rst, clock, reset |=> !rsp_valid, "result after reset")
endmodule

bind best_fit_page_allocator_top bfpa_checker u_bfpa_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_data(rsp_data)
);
